// ===== sv/piltbl_pkg.sv =====
// Shared types and constants for the per-user in-flight limit table.
// No dependencies; imported by every module of the block.
package piltbl_pkg;

  localparam int USER_W = 64;
  localparam int CNT_W  = 8;
  localparam int MODE_W = 2;
  localparam int USED_W = 5;

  // used_slots saturates here for tables wider than the field
  localparam int USED_MAX = 31;

  localparam logic [CNT_W-1:0] MAX_PER_USER_RST = 8'd4;

  // Request modes; the unused code is handled as a query
  typedef enum logic [MODE_W-1:0] {
    MODE_ACQUIRE = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_QUERY   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  // One table entry; user zero marks a free slot
  typedef struct packed {
    logic [USER_W-1:0] user;
    logic [CNT_W-1:0]  count;
  } slot_t;

  // Broadcast command to every cell
  typedef struct packed {
    logic  shift;
    logic  wr;
    slot_t wdata;
  } cell_cmd_t;

endpackage

// ===== sv/per_user_inflight_limit_table.sv =====
// Per-user in-flight limit table: top level.
// Instantiates the slot cells (piltbl_cell) and the scan accumulator (piltbl_scan).
// Depends on piltbl_pkg.
//
// Usage:
//   Input stream: in_tuser carries the mode (acquire, release, query; code 3 acts as
//   query), in_tdata the 64-bit user id. Each item yields exactly one result item.
//   Result stream: out_tdata = {pad, used_slots, held, granted}.
//   Config: cfg_we with cfg_wdata writes max_per_user (reset value 4); write only
//   while no item is in progress.
//
// Timing:
//   The slots sit in a ring of TABLE_SLOTS cells that rotates one position per
//   cycle while a scan runs; the scan unit inspects the head cell at each scan
//   step. After a full turn the ring is back in place and the apply state writes
//   the selected cell and loads the output register. A new item is accepted
//   only once the previous one has left the apply state.
//   The next item is accepted while a result still waits in the output register;
//   it only holds in its apply cycle if that register is still occupied.
//   A stalled receiver therefore costs nothing until the next apply.
//
// Reset: rst_n clears every slot (empty table), the limit to 4, and the channels.
module per_user_inflight_limit_table
  import piltbl_pkg::*;
#(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // max_per_user
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // [63:0] user_id
  input  logic [1:0]  in_tuser,      // [1:0] mode
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // [0] granted, [8:1] held, [13:9] used_slots, [15:14] 0
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int NUM_W = $clog2(TABLE_SLOTS + 1);
  localparam int SAT_W = (NUM_W > USED_W) ? NUM_W : USED_W;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  max_r;
  mode_t             mode_r;
  logic [USER_W-1:0] uid_r;

  logic              in_acc;
  logic              apply_go;

  // scan results
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic [CNT_W-1:0]  hit_cnt;
  logic              free;
  logic [IDX_W-1:0]  empty_idx;
  logic [NUM_W-1:0]  used;

  // apply decision
  logic              wr;
  logic [IDX_W-1:0]  wr_idx;
  slot_t             wdata;
  logic              granted;
  logic [CNT_W-1:0]  held;
  logic [NUM_W-1:0]  used_new;
  logic [SAT_W-1:0]  used_ext;
  logic [USED_W-1:0] used_out;

  // output register
  logic              out_tvalid_r;
  logic [15:0]       out_tdata_r;

  cell_cmd_t         cmd;
  slot_t             slots [TABLE_SLOTS];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign apply_go  = (state_r == ST_APPLY) && (!out_tvalid_r || out_tready);

  // ---------------- control FSM ----------------
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (in_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k_r == IDX_W'(TABLE_SLOTS - 1)) begin
          k_nxt     = '0;
          state_nxt = ST_APPLY;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_APPLY: begin
        if (apply_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        k_nxt     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      max_r   <= MAX_PER_USER_RST;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= mode_t'(in_tuser);
      uid_r  <= in_tdata;
    end
  end

  // ---------------- cell ring ----------------
  assign cmd.shift = (state_r == ST_SCAN);
  assign cmd.wr    = apply_go && wr;
  assign cmd.wdata = wdata;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    piltbl_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .sel   (wr_idx == IDX_W'(i)),
      .nbr   (slots[(i + 1) % TABLE_SLOTS]),
      .slot  (slots[i])
    );
  end

  // head cell holds original slot k during the turn
  piltbl_scan #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (in_acc),
    .step      (state_r == ST_SCAN),
    .idx       (k_r),
    .head      (slots[0]),
    .uid       (uid_r),
    .hit       (hit),
    .hit_idx   (hit_idx),
    .hit_cnt   (hit_cnt),
    .free      (free),
    .empty_idx (empty_idx),
    .used      (used)
  );

  // ---------------- apply ----------------
  always_comb begin
    wr          = 1'b0;
    wr_idx      = hit_idx;
    wdata.user  = uid_r;
    wdata.count = hit_cnt;
    granted     = 1'b0;
    held        = '0;
    used_new    = used;
    case (mode_r)
      MODE_ACQUIRE: begin
        if (uid_r != '0) begin
          if (hit) begin
            // refused at or above the limit, even if the limit dropped later
            if (hit_cnt < max_r) begin
              wr          = 1'b1;
              wdata.count = hit_cnt + CNT_W'(1);
              granted     = 1'b1;
              held        = hit_cnt + CNT_W'(1);
            end else begin
              held = hit_cnt;
            end
          end else if (free) begin
            // new user claims the lowest free slot
            wr          = 1'b1;
            wr_idx      = empty_idx;
            wdata.count = CNT_W'(1);
            granted     = 1'b1;
            held        = CNT_W'(1);
            used_new    = used + NUM_W'(1);
          end
        end
      end
      MODE_RELEASE: begin
        if (hit) begin
          wr = 1'b1;
          if (hit_cnt > CNT_W'(1)) begin
            wdata.count = hit_cnt - CNT_W'(1);
            held        = hit_cnt - CNT_W'(1);
          end else begin
            // count reaches zero: free the slot
            wdata    = '0;
            used_new = used - NUM_W'(1);
          end
        end
      end
      default: begin
        held = hit ? hit_cnt : '0;
      end
    endcase
  end

  assign used_ext = SAT_W'(used_new);
  assign used_out = (used_ext > SAT_W'(USED_MAX)) ? USED_W'(USED_MAX)
                                                  : used_ext[USED_W-1:0];

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (apply_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_tdata_r <= {2'b00, used_out, held, granted};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // ---------------- assertions ----------------
  a_idle_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (k_r == '0))
    else $error("scan pointer not parked while idle");

  a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_SCAN))
    else $error("accepted item did not start a scan");

  a_apply_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY && out_tvalid_r && !out_tready) |=> (state_r == ST_APPLY))
    else $error("apply overran a pending result");

  a_grant_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[0]) |-> (out_tdata_r[8:1] != '0))
    else $error("grant with zero held count");

endmodule

// ===== sv/piltbl_cell.sv =====
// One table slot: holds a user id and its in-flight count.
// Rotates its entry to the neighbor on shift, or takes a selected write.
// Depends on piltbl_pkg.
module piltbl_cell
  import piltbl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  logic      sel,
  input  slot_t     nbr,
  output slot_t     slot
);

  slot_t slot_r;
  slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (cmd.shift) begin
      slot_nxt = nbr;
    end else if (cmd.wr && sel) begin
      slot_nxt = cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot = slot_r;

endmodule

// ===== sv/piltbl_scan.sv =====
// Scan accumulator: looks at the head cell once per step while the ring rotates.
// Records the matching slot, the first free slot and the occupancy.
// Depends on piltbl_pkg.
module piltbl_scan
  import piltbl_pkg::*;
#(
  parameter  int TABLE_SLOTS = 16,
  localparam int IDX_W       = $clog2(TABLE_SLOTS),
  localparam int NUM_W       = $clog2(TABLE_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              step,
  input  logic [IDX_W-1:0]  idx,
  input  slot_t             head,
  input  logic [USER_W-1:0] uid,
  output logic              hit,
  output logic [IDX_W-1:0]  hit_idx,
  output logic [CNT_W-1:0]  hit_cnt,
  output logic              free,
  output logic [IDX_W-1:0]  empty_idx,
  output logic [NUM_W-1:0]  used
);

  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic             free_r, free_nxt;
  logic [IDX_W-1:0] empty_idx_r, empty_idx_nxt;
  logic [NUM_W-1:0] used_r, used_nxt;
  logic             occupied;

  assign occupied = (head.user != '0);

  always_comb begin
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    free_nxt      = free_r;
    empty_idx_nxt = empty_idx_r;
    used_nxt      = used_r;
    if (clear) begin
      hit_nxt  = 1'b0;
      free_nxt = 1'b0;
      used_nxt = '0;
    end else if (step) begin
      // anonymous user never matches an occupied slot
      if (!hit_r && (uid != '0) && (head.user == uid)) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = idx;
        hit_cnt_nxt = head.count;
      end
      if (!free_r && !occupied) begin
        free_nxt      = 1'b1;
        empty_idx_nxt = idx;
      end
      if (occupied) begin
        used_nxt = used_r + NUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      used_r <= '0;
    end else begin
      hit_r  <= hit_nxt;
      free_r <= free_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r   <= hit_idx_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    empty_idx_r <= empty_idx_nxt;
  end

  assign hit       = hit_r;
  assign hit_idx   = hit_idx_r;
  assign hit_cnt   = hit_cnt_r;
  assign free      = free_r;
  assign empty_idx = empty_idx_r;
  assign used      = used_r;

endmodule
